// ===== hdl/pulse_period_duty_meter_macros.svh =====
// Assertion macros shared by the pulse period and duty meter RTL.
// Each macro takes a label, the clock, the active-low reset, two expressions
// and a message string.
`ifndef PULSE_PERIOD_DUTY_METER_MACROS_SVH
`define PULSE_PERIOD_DUTY_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPDM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ppdm_pkg.sv =====
`timescale 1ns / 1ps

package ppdm_pkg;

    localparam int PIN_W   = 4;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int DUTY_W  = 7;
    localparam int TOTAL_W = 64;

    // Width of the shared subtractor; covers a 32-bit width times 100.
    localparam int UNIT_W  = 40;

    // The quotient is below 100, so seven restoring steps produce it.
    localparam int DIV_STEPS = 7;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int PCT_SCALE = 100;

    // Reset value of the measured pin selection.
    localparam logic [PIN_W-1:0] DEFAULT_PIN = '0;

endpackage

// ===== hdl/ppdm_if.sv =====
`timescale 1ns / 1ps

// Edge event channel.
interface ppdm_evt_if;
    import ppdm_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIN_W-1:0]  pin_number;
    logic              level_high;
    logic [TIME_W-1:0] timestamp_us;
    logic [CNT_W-1:0]  pulse_counter;

    modport source (output valid, output pin_number, output level_high,
                    output timestamp_us, output pulse_counter, input ready);
    modport sink   (input valid, input pin_number, input level_high,
                    input timestamp_us, input pulse_counter, output ready);
endinterface

// Measurement result channel.
interface ppdm_res_if;
    import ppdm_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  period_us;
    logic [TIME_W-1:0]  high_width_us;
    logic [TIME_W-1:0]  low_width_us;
    logic [DUTY_W-1:0]  duty_percent;
    logic [TOTAL_W-1:0] pulse_total;

    modport source (output valid, output period_us, output high_width_us,
                    output low_width_us, output duty_percent, output pulse_total,
                    input ready);
    modport sink   (input valid, input period_us, input high_width_us,
                    input low_width_us, input duty_percent, input pulse_total,
                    output ready);
endinterface

// ===== hdl/pulse_period_duty_meter.sv =====
// A rising edge passes through S_RISE and S_DONE, a falling edge through S_F_PER,
// S_F_HIGH, S_F_CNT and S_F_CMP, then S_F_MUL and 7 divide steps when the duty
// percent is recomputed, then S_DONE. A new event is taken only in S_IDLE.
// Events on other pins are accepted and give no result.
// Reset (rst_n, asynchronous, active low) clears all measurements and selects pin 0.
`timescale 1ns / 1ps
`include "pulse_period_duty_meter_macros.svh"

module pulse_period_duty_meter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ppdm_pkg::PIN_W-1:0] cfg_wdata,
    ppdm_evt_if.sink                   evt,
    ppdm_res_if.source                 res
);
    import ppdm_pkg::*;

    // The sequencer walks one event through a list of steps. Each subtraction
    // that a step needs borrows the single shared subtractor below: time
    // differences, the counter advance, the duty qualification compare and
    // the restoring divide steps all go through it in turn.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RISE   = 4'd1;
    localparam logic [3:0] S_F_PER  = 4'd2;
    localparam logic [3:0] S_F_HIGH = 4'd3;
    localparam logic [3:0] S_F_CNT  = 4'd4;
    localparam logic [3:0] S_F_CMP  = 4'd5;
    localparam logic [3:0] S_F_MUL  = 4'd6;
    localparam logic [3:0] S_F_DIV  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [PIN_W-1:0]     pin_reg;

    // Captured event payload.
    logic [TIME_W-1:0]    t_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // Measurement state. A stored time of zero means that edge was not seen.
    logic [TIME_W-1:0]    rise_time_reg;
    logic [TIME_W-1:0]    fall_time_reg;
    logic [TIME_W-1:0]    prev_fall_time_reg;
    logic [TIME_W-1:0]    period_reg;
    logic [TIME_W-1:0]    high_width_reg;
    logic [TIME_W-1:0]    low_width_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic                 first_seen_reg;
    logic [CNT_W-1:0]     last_counter_reg;
    logic [TOTAL_W-1:0]   total_reg;

    // Divider working registers.
    logic [UNIT_W-1:0]    rem_reg;
    logic [DUTY_W-2:0]    quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Output register, so that a waiting result does not hold up the sequencer
    // until the next event actually has a result to deliver.
    logic                 out_valid_reg;
    logic [TIME_W-1:0]    out_period_reg;
    logic [TIME_W-1:0]    out_high_reg;
    logic [TIME_W-1:0]    out_low_reg;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    // Shared subtractor.
    logic [UNIT_W-1:0]    unit_a;
    logic [UNIT_W-1:0]    unit_b;
    logic [UNIT_W:0]      unit_diff;
    logic                 unit_borrow;

    logic                 evt_xfer;
    logic                 res_xfer;
    logic                 out_load;
    logic                 duty_go;
    logic [UNIT_W-1:0]    product;

    assign evt.ready = (state_reg == S_IDLE);
    assign evt_xfer  = evt.valid && evt.ready;
    assign res_xfer  = res.valid && res.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || res.ready);

    assign res.valid         = out_valid_reg;
    assign res.period_us     = out_period_reg;
    assign res.high_width_us = out_high_reg;
    assign res.low_width_us  = out_low_reg;
    assign res.duty_percent  = out_duty_reg;
    assign res.pulse_total   = out_total_reg;

    // Operand selection for the shared subtractor, driven by the current step.
    always_comb
    begin
        unit_a = '0;
        unit_b = '0;
        unique case (state_reg)
            S_RISE:
            begin
                unit_a = UNIT_W'(t_reg);
                unit_b = UNIT_W'(fall_time_reg);
            end
            S_F_PER:
            begin
                unit_a = UNIT_W'(t_reg);
                unit_b = UNIT_W'(fall_time_reg);
            end
            S_F_HIGH:
            begin
                unit_a = UNIT_W'(t_reg);
                unit_b = UNIT_W'(rise_time_reg);
            end
            S_F_CNT:
            begin
                unit_a = UNIT_W'(cnt_reg);
                unit_b = UNIT_W'(last_counter_reg);
            end
            S_F_CMP:
            begin
                unit_a = UNIT_W'(high_width_reg);
                unit_b = UNIT_W'(period_reg);
            end
            S_F_DIV:
            begin
                unit_a = rem_reg;
                unit_b = UNIT_W'(period_reg) << div_cnt_reg;
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_borrow = unit_diff[UNIT_W];

    // The duty percent is refreshed only from the second falling edge on, and
    // only when period and high width are known and high width is below the period.
    assign duty_go = unit_borrow && (period_reg != '0) && (high_width_reg != '0)
                     && first_seen_reg;

    // High width times 100, written as a sum of shifts (64 + 32 + 4).
    assign product = (UNIT_W'(high_width_reg) << 6) + (UNIT_W'(high_width_reg) << 5)
                     + (UNIT_W'(high_width_reg) << 2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_xfer && (evt.pin_number == pin_reg))
                begin
                    state_next = evt.level_high ? S_RISE : S_F_PER;
                end
            end
            S_RISE:   state_next = S_DONE;
            S_F_PER:  state_next = S_F_HIGH;
            S_F_HIGH: state_next = S_F_CNT;
            S_F_CNT:  state_next = S_F_CMP;
            S_F_CMP:  state_next = duty_go ? S_F_MUL : S_DONE;
            S_F_MUL:  state_next = S_F_DIV;
            S_F_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            pin_reg            <= DEFAULT_PIN;
            rise_time_reg      <= '0;
            fall_time_reg      <= '0;
            prev_fall_time_reg <= '0;
            period_reg         <= '0;
            high_width_reg     <= '0;
            low_width_reg      <= '0;
            duty_reg           <= '0;
            first_seen_reg     <= 1'b0;
            last_counter_reg   <= '0;
            total_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                pin_reg <= cfg_wdata;
            end

            unique case (state_reg)
                S_RISE:
                begin
                    rise_time_reg <= t_reg;
                    if (fall_time_reg != '0)
                    begin
                        low_width_reg <= unit_diff[TIME_W-1:0];
                    end
                end
                S_F_PER:
                begin
                    prev_fall_time_reg <= fall_time_reg;
                    fall_time_reg      <= t_reg;
                    if (fall_time_reg != '0)
                    begin
                        period_reg <= unit_diff[TIME_W-1:0];
                    end
                end
                S_F_HIGH:
                begin
                    if (rise_time_reg != '0)
                    begin
                        high_width_reg <= unit_diff[TIME_W-1:0];
                    end
                end
                S_F_CNT:
                begin
                    // The advance wraps at 32 bits before it enters the total.
                    last_counter_reg <= cnt_reg;
                    total_reg        <= total_reg + TOTAL_W'(unit_diff[CNT_W-1:0]);
                end
                S_F_CMP:
                begin
                    first_seen_reg <= 1'b1;
                end
                S_F_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        duty_reg <= {quo_reg, !unit_borrow};
                    end
                end
                default:
                begin
                end
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and divider registers need no reset.
    always_ff @(posedge clk)
    begin
        if (evt_xfer)
        begin
            t_reg   <= evt.timestamp_us;
            cnt_reg <= evt.pulse_counter;
        end

        if (state_reg == S_F_MUL)
        begin
            rem_reg     <= product;
            quo_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (state_reg == S_F_DIV)
        begin
            if (!unit_borrow)
            begin
                rem_reg <= unit_diff[UNIT_W-1:0];
            end
            quo_reg     <= {quo_reg[DUTY_W-3:0], !unit_borrow};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end

        if (out_load)
        begin
            out_period_reg <= period_reg;
            out_high_reg   <= high_width_reg;
            out_low_reg    <= low_width_reg;
            out_duty_reg   <= duty_reg;
            out_total_reg  <= total_reg;
        end
    end

    `PPDM_ASSERT_NEXT(a_done_loads_output, clk, rst_n, out_load,
                      res.valid && (state_reg == S_IDLE),
                      "finished result did not reach the output register")
    `PPDM_ASSERT_NEXT(a_other_pin_ignored, clk, rst_n,
                      evt_xfer && (evt.pin_number != pin_reg), state_reg == S_IDLE,
                      "event on another pin started a measurement")
    `PPDM_ASSERT_NEXT(a_duty_in_range, clk, rst_n,
                      (state_reg == S_F_DIV) && (div_cnt_reg == '0),
                      duty_reg < DUTY_W'(PCT_SCALE),
                      "duty percent out of range after divide")
    `PPDM_ASSERT_NEXT(a_first_seen_sticky, clk, rst_n, first_seen_reg, first_seen_reg,
                      "first falling edge flag cleared")

endmodule
